// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the frame receiver RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/ccfr_pkg.sv
// ----------------------------------------------------------------------------
// Frame receiver package
// Types, constants and the CRC step shared by the frame receiver modules.
// ----------------------------------------------------------------------------
package ccfr_pkg;

  localparam int unsigned HdrLen = 6;
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [7:0]  CodeFull = 8'hFF;
  localparam logic [7:0]  VersionReset = 8'd1;
  localparam int unsigned RawOverhead = 8;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_OVERFLOW  = 4'd1,
    ST_TRUNCATED = 4'd2,
    ST_RAW_OVF   = 4'd3,
    ST_SHORT     = 4'd4,
    ST_PLEN_LONG = 4'd5,
    ST_LENGTH    = 4'd6,
    ST_CRC       = 4'd7,
    ST_SEQ_ZERO  = 4'd8,
    ST_VERSION   = 4'd9
  } ccfr_status_e;

  typedef struct packed {
    logic         kind;
    logic [15:0]  pay_len;
    logic [15:0]  sequence_num;
    logic [7:0]   command;
    logic [7:0]   version;
    ccfr_status_e status;
    logic [8:0]   byte_index;
    logic [7:0]   data_byte;
  } ccfr_result_t;

  function automatic logic [15:0] crc16_step(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/cobs_crc_frame_receiver.sv
// ----------------------------------------------------------------------------
// COBS frame receiver with CRC-16 check
// Top level: byte stream in, decoded bytes and end-of-frame verdicts out.
// ----------------------------------------------------------------------------
// The result of each accepted byte, if any, is ready in the next cycle,
// so a byte can be accepted on every clock while the output
// side keeps up. A two-entry result queue sits between the decoder and the
// output port; the input stalls only when both entries hold results that
// have not been taken. Decoded bytes carry kind 0 on tuser; a verdict with
// kind 1 follows each non-empty frame, and its status must be zero for the
// preceding bytes of that frame to be kept. The expected version register
// resets to one and should be written only while the receiver is idle.

module cobs_crc_frame_receiver #(
  parameter int unsigned MAX_ENCODED_LEN = 260,
  parameter int unsigned MAX_RAW_LEN     = 256,
  parameter int unsigned MAX_PAYLOAD_LEN = 248
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // rx_byte
  input  logic [7:0]  s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // data_byte, byte_index, status, frame_version, frame_command,
  // frame_sequence, frame payload length, zero fill
  output logic [71:0] m_axis_tdata,
  // kind
  output logic        m_axis_tuser
);
  import ccfr_pkg::*;

  logic         accept;
  logic         res_valid;
  ccfr_result_t res;
  ccfr_result_t out_res;

  assign accept = s_axis_tvalid && s_axis_tready;

  ccfr_core #(
    .MAX_ENCODED_LEN(MAX_ENCODED_LEN),
    .MAX_RAW_LEN    (MAX_RAW_LEN),
    .MAX_PAYLOAD_LEN(MAX_PAYLOAD_LEN)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .accept_i   (accept),
    .rx_byte_i  (s_axis_tdata),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  ccfr_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .push_data_i(res),
    .space_o    (s_axis_tready),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .data_o     (out_res)
  );

  assign m_axis_tuser = out_res.kind;
  assign m_axis_tdata = {3'b000, out_res.pay_len, out_res.sequence_num,
                         out_res.command, out_res.version, 4'(out_res.status),
                         out_res.byte_index, out_res.data_byte};

endmodule

// File: hw/rtl/ccfr_core.sv
// ----------------------------------------------------------------------------
// Frame receiver core
// COBS decoding, CRC accumulation, header capture and end-of-frame verdict.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ccfr_core #(
  parameter int unsigned MAX_ENCODED_LEN = 260,
  parameter int unsigned MAX_RAW_LEN     = 256,
  parameter int unsigned MAX_PAYLOAD_LEN = 248
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [7:0]            cfg_wdata_i,
  input  logic                  accept_i,
  input  logic [7:0]            rx_byte_i,
  output logic                  res_valid_o,
  output ccfr_pkg::ccfr_result_t res_o
);
  import ccfr_pkg::*;

  logic [7:0]   exp_version_q;
  logic [8:0]   enc_cnt_q, enc_cnt_d;
  logic         ovf_q, ovf_d;
  logic         dec_err_q, dec_err_d;
  logic [7:0]   grp_rem_q, grp_rem_d;
  logic         prev_full_q, prev_full_d;
  logic [8:0]   raw_cnt_q, raw_cnt_d;
  logic [15:0]  crc_q, crc_d;
  logic [7:0]   tail_q [2];
  logic [7:0]   tail_d [2];
  logic [7:0]   hdr_q [HdrLen];
  logic [7:0]   hdr_d [HdrLen];

  logic         take_en;
  logic [7:0]   take_val;
  logic [8:0]   raw_after;
  logic [15:0]  plen;
  logic [15:0]  seq;
  ccfr_status_e verdict;

  assign plen = {hdr_q[5], hdr_q[4]};
  assign seq  = {hdr_q[3], hdr_q[2]};

  always_comb begin
    if (ovf_q) begin
      verdict = ST_OVERFLOW;
    end else if (grp_rem_q != 8'd0) begin
      verdict = ST_TRUNCATED;
    end else if (dec_err_q) begin
      verdict = ST_RAW_OVF;
    end else if (raw_cnt_q < 9'(RawOverhead)) begin
      verdict = ST_SHORT;
    end else if (plen > 16'(MAX_PAYLOAD_LEN)) begin
      verdict = ST_PLEN_LONG;
    end else if ({8'd0, raw_cnt_q} != ({1'b0, plen} + 17'(RawOverhead))) begin
      verdict = ST_LENGTH;
    end else if (crc_q != {tail_q[1], tail_q[0]}) begin
      verdict = ST_CRC;
    end else if (seq == 16'd0) begin
      verdict = ST_SEQ_ZERO;
    end else if (hdr_q[0] != exp_version_q) begin
      verdict = ST_VERSION;
    end else begin
      verdict = ST_OK;
    end
  end

  always_comb begin
    enc_cnt_d   = enc_cnt_q;
    ovf_d       = ovf_q;
    dec_err_d   = dec_err_q;
    grp_rem_d   = grp_rem_q;
    prev_full_d = prev_full_q;
    raw_cnt_d   = raw_cnt_q;
    crc_d       = crc_q;
    tail_d      = tail_q;
    hdr_d       = hdr_q;
    take_en     = 1'b0;
    take_val    = 8'd0;
    raw_after   = raw_cnt_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (accept_i) begin
      if (rx_byte_i == 8'd0) begin
        if (enc_cnt_q != 9'd0) begin
          res_valid_o          = 1'b1;
          res_o.kind           = 1'b1;
          res_o.byte_index     = raw_cnt_q;
          res_o.status         = verdict;
          res_o.version        = hdr_q[0];
          res_o.command        = hdr_q[1];
          res_o.sequence_num   = seq;
          res_o.pay_len        = plen;
        end
        enc_cnt_d   = 9'd0;
        ovf_d       = 1'b0;
        dec_err_d   = 1'b0;
        grp_rem_d   = 8'd0;
        prev_full_d = 1'b1;
        raw_cnt_d   = 9'd0;
        crc_d       = CrcInit;
        tail_d      = '{default: 8'd0};
        hdr_d       = '{default: 8'd0};
      end else if (!ovf_q) begin
        if (enc_cnt_q >= 9'(MAX_ENCODED_LEN)) begin
          ovf_d = 1'b1;
        end else begin
          enc_cnt_d = enc_cnt_q + 9'd1;
          if (grp_rem_q == 8'd0) begin
            if (!prev_full_q && !dec_err_q) begin
              if (raw_cnt_q >= 9'(MAX_RAW_LEN)) begin
                dec_err_d = 1'b1;
              end else begin
                take_en = 1'b1;
              end
            end
            raw_after = raw_cnt_q + {8'd0, take_en};
            if (!dec_err_d &&
                (({1'b0, raw_after} + {2'b00, rx_byte_i}) > 10'(MAX_RAW_LEN + 1))) begin
              dec_err_d = 1'b1;
            end
            grp_rem_d   = rx_byte_i - 8'd1;
            prev_full_d = (rx_byte_i == CodeFull);
          end else begin
            grp_rem_d = grp_rem_q - 8'd1;
            if (!dec_err_q) begin
              take_en  = 1'b1;
              take_val = rx_byte_i;
            end
          end
        end
      end
    end

    if (take_en) begin
      if (raw_cnt_q >= 9'd2) begin
        crc_d = crc16_step(crc_q, tail_q[0]);
      end
      tail_d[0] = tail_q[1];
      tail_d[1] = take_val;
      for (int i = 0; i < HdrLen; i++) begin
        if (raw_cnt_q == 9'(i)) begin
          hdr_d[i] = take_val;
        end
      end
      raw_cnt_d        = raw_cnt_q + 9'd1;
      res_valid_o      = 1'b1;
      res_o.data_byte  = take_val;
      res_o.byte_index = raw_cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_version_q <= VersionReset;
      enc_cnt_q     <= 9'd0;
      ovf_q         <= 1'b0;
      dec_err_q     <= 1'b0;
      grp_rem_q     <= 8'd0;
      prev_full_q   <= 1'b1;
      raw_cnt_q     <= 9'd0;
      crc_q         <= CrcInit;
      tail_q        <= '{default: 8'd0};
      hdr_q         <= '{default: 8'd0};
    end else begin
      if (cfg_we_i) begin
        exp_version_q <= cfg_wdata_i;
      end
      enc_cnt_q   <= enc_cnt_d;
      ovf_q       <= ovf_d;
      dec_err_q   <= dec_err_d;
      grp_rem_q   <= grp_rem_d;
      prev_full_q <= prev_full_d;
      raw_cnt_q   <= raw_cnt_d;
      crc_q       <= crc_d;
      tail_q      <= tail_d;
      hdr_q       <= hdr_d;
    end
  end

  `ASSERT_ALWAYS(a_raw_bound, clk_i, rst_ni, raw_cnt_q <= 9'(MAX_RAW_LEN))
  `ASSERT_IMPLIES(a_ovf_full, clk_i, rst_ni, ovf_q, enc_cnt_q == 9'(MAX_ENCODED_LEN))
  `ASSERT_NEXT(a_delim_clears, clk_i, rst_ni, accept_i && (rx_byte_i == 8'd0),
               (enc_cnt_q == 9'd0) && (raw_cnt_q == 9'd0) && !ovf_q)

endmodule

// File: hw/rtl/ccfr_out_buf.sv
// ----------------------------------------------------------------------------
// Frame receiver output buffer
// Two-entry result queue that lets the input keep flowing while a result waits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ccfr_out_buf (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  ccfr_pkg::ccfr_result_t push_data_i,
  output logic                  space_o,
  output logic                  valid_o,
  input  logic                  ready_i,
  output ccfr_pkg::ccfr_result_t data_o
);
  import ccfr_pkg::*;

  ccfr_result_t slot_q [2];
  logic [1:0]   count_q;
  logic         wr_ptr_q;
  logic         rd_ptr_q;
  logic         pop;

  assign valid_o = (count_q != 2'd0);
  assign space_o = (count_q != 2'd2);
  assign data_o  = slot_q[rd_ptr_q];
  assign pop     = valid_o && ready_i;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop};
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  `ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, count_q != 2'd3)
  `ASSERT_IMPLIES(a_no_push_full, clk_i, rst_ni, push_i, count_q != 2'd2)
  `ASSERT_NEXT(a_pop_only, clk_i, rst_ni, pop && !push_i,
               count_q == ($past(count_q) - 2'd1))

endmodule
